>>> design/assert_macros.svh
// Assertion shorthands shared by the hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Condition must never be true out of reset.
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) else $error(msg);

`endif

>>> design/sha1h_pkg.sv
package sha1h_pkg;

  // Five chaining words, index 0 is the most significant digest word
  typedef logic [4:0][31:0] chain_t;

  localparam chain_t CHAIN_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                   32'hEFCDAB89, 32'h67452301};

  localparam logic [6:0] LAST_ROUND    = 7'd79;
  localparam logic [6:0] SCHED_DIRECT  = 7'd16;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;
  localparam logic [5:0] LAST_BYTE_POS = 6'd63;
  localparam logic [5:0] LEN_POS       = 6'd56;
  localparam logic [3:0] LEN_BYTES     = 4'd8;
  localparam logic [7:0] PAD_MARK      = 8'h80;

  // Sequencer to compression unit
  typedef struct packed {
    logic       load;   // shift one byte into the block buffer
    logic       start;  // begin the 80 rounds
    logic       init;   // restore the initial chaining words
    logic [7:0] data;
  } cmp_ctrl_t;

  // Compression unit back to sequencer
  typedef struct packed {
    logic busy;
    logic done;  // chaining words updated at this edge
  } cmp_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    if (rnd < 7'd20) begin
      return 32'h5A827999;
    end else if (rnd < 7'd40) begin
      return 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      return 32'h8F1BBCDC;
    end else begin
      return 32'hCA62C1D6;
    end
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (rnd < 7'd20) begin
      return (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      return b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      return (b & c) | (b & d) | (c & d);
    end else begin
      return b ^ c ^ d;
    end
  endfunction

endpackage

>>> design/sha1_message_hasher_unit.sv
// SHA-1 hasher over a byte stream.
// Input channel (in_valid/in_ready): each word may carry one message byte
// (byte_valid) and may close the message (message_end); the byte, if any,
// belongs to the message. Output channel (out_valid/out_ready): five digest
// words, word_index 0..4, last_word set on the fifth.
// A byte word is taken while in_ready is high; every 64th byte starts a
// compression (80 rounds on one shared round unit plus the chaining fold)
// during which in_ready is low. After a message_end word the block pads with
// the marker byte, zero fill and the length bytes, going on into a second
// block when the length does not fit behind the marker, compresses each
// padded block and then loads the digest words into the output register.
// The output register lets the block take new input while the last digest
// word waits; a stalled receiver holds digest emission and so the block.
// Reset restores the initial chaining words and clears the position and the
// bit count; after the fifth word the block starts a new message itself.
`include "assert_macros.svh"

module sha1_message_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1h_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PAD  = 2'd1;
  localparam logic [1:0] S_COMP = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state;
  logic [5:0]  pos;
  logic [63:0] bit_cnt;
  logic        mark_done;
  logic [3:0]  len_cnt;
  logic        pad_active;
  logic [2:0]  out_idx;
  logic        out_valid_q;

  cmp_ctrl_t   ctl;
  cmp_stat_t   stat;
  chain_t      chain;
  logic        accept;
  logic        out_load;
  logic        zero_fill;
  logic [7:0]  pad_byte;

  sha1h_compress u_compress (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .stat  (stat),
    .chain (chain)
  );

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_load  = (state == S_OUT) && (!out_valid_q || out_ready);
  assign out_valid = out_valid_q;
  assign zero_fill = (len_cnt == 4'd0) && (pos != LEN_POS);

  // padding byte: marker, zero fill, then length high byte first
  always_comb begin
    if (!mark_done) begin
      pad_byte = PAD_MARK;
    end else if (zero_fill) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = bit_cnt[63:56];
    end
  end

  // commands to the compression unit
  always_comb begin
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (accept && byte_valid) begin
          ctl.load  = 1'b1;
          ctl.data  = data_byte;
          ctl.start = (pos == LAST_BYTE_POS);
        end
      end
      S_PAD: begin
        ctl.load  = 1'b1;
        ctl.data  = pad_byte;
        ctl.start = (pos == LAST_BYTE_POS);
      end
      S_OUT: begin
        ctl.init = out_load && (out_idx == LAST_WORD_IDX);
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos         <= '0;
      bit_cnt     <= '0;
      mark_done   <= 1'b0;
      len_cnt     <= '0;
      pad_active  <= 1'b0;
      out_idx     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pad_active <= message_end;
            if (byte_valid) begin
              bit_cnt <= bit_cnt + 64'd8;
              pos     <= pos + 6'd1;
            end
            if (byte_valid && (pos == LAST_BYTE_POS)) begin
              state <= S_COMP;
            end else if (message_end) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pos <= pos + 6'd1;
          if (!mark_done) begin
            mark_done <= 1'b1;
          end else if (!zero_fill) begin
            bit_cnt <= {bit_cnt[55:0], 8'h00};
            len_cnt <= len_cnt + 4'd1;
          end
          if (pos == LAST_BYTE_POS) begin
            state <= S_COMP;
          end
        end
        S_COMP: begin
          if (stat.done) begin
            if (!pad_active) begin
              state <= S_IDLE;
            end else if (len_cnt == LEN_BYTES) begin
              state <= S_OUT;
            end else begin
              state <= S_PAD;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            if (out_idx == LAST_WORD_IDX) begin
              state      <= S_IDLE;
              out_idx    <= '0;
              pos        <= '0;
              bit_cnt    <= '0;
              mark_done  <= 1'b0;
              len_cnt    <= '0;
              pad_active <= 1'b0;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // digest output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      digest_word <= chain[out_idx];
      word_index  <= out_idx;
      last_word   <= (out_idx == LAST_WORD_IDX);
    end
  end

  `ASSERT_NEVER(a_ready_while_busy, clk, rst, in_ready && stat.busy,
                "input taken during compression")
  `ASSERT_CLK(a_start_at_wrap, clk, rst, ctl.start |-> (pos == LAST_BYTE_POS),
              "compression off block end")
  `ASSERT_CLK(a_out_aligned, clk, rst,
              (state == S_OUT) |-> ((pos == 6'd0) && (len_cnt == LEN_BYTES)),
              "digest before padding done")
  `ASSERT_CLK(a_last_tag, clk, rst,
              (out_valid && last_word) |-> (word_index == LAST_WORD_IDX),
              "last_word on wrong index")

endmodule

>>> design/sha1h_round.sv
// One SHA-1 round: schedule word and new working word
module sha1h_round (
  input  logic [6:0]  rnd,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  input  logic [31:0] e,
  input  logic [31:0] s0,
  input  logic [31:0] s2,
  input  logic [31:0] s8,
  input  logic [31:0] s13,
  output logic [31:0] wt,
  output logic [31:0] tmp
);
  import sha1h_pkg::*;

  // first 16 rounds take the block words as they stand
  always_comb begin
    if (rnd < SCHED_DIRECT) begin
      wt = s0;
    end else begin
      wt = rotl(s13 ^ s8 ^ s2 ^ s0, 1);
    end
    tmp = rotl(a, 5) + round_f(rnd, b, c, d) + e + round_k(rnd) + wt;
  end

endmodule

>>> design/sha1h_compress.sv
`include "assert_macros.svh"

// Block buffer, message schedule and 80-round iteration over one round unit
module sha1h_compress (
  input  logic                 clk,
  input  logic                 rst,
  input  sha1h_pkg::cmp_ctrl_t ctl,
  output sha1h_pkg::cmp_stat_t stat,
  output sha1h_pkg::chain_t    chain
);
  import sha1h_pkg::*;

  // blk[511:480] is the oldest schedule word; bytes shift in at the bottom
  logic [511:0] blk;
  logic [31:0]  a, b, c, d, e;
  logic [6:0]   rnd;
  logic         running;
  logic         fin;
  logic [31:0]  wt;
  logic [31:0]  tmp;

  sha1h_round u_round (
    .rnd (rnd),
    .a   (a),
    .b   (b),
    .c   (c),
    .d   (d),
    .e   (e),
    .s0  (blk[511:480]),
    .s2  (blk[447:416]),
    .s8  (blk[255:224]),
    .s13 (blk[95:64]),
    .wt  (wt),
    .tmp (tmp)
  );

  // round control and chaining words
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      rnd     <= '0;
      chain   <= CHAIN_INIT;
    end else begin
      fin <= running && (rnd == LAST_ROUND);
      if (ctl.start) begin
        running <= 1'b1;
        rnd     <= '0;
      end else if (running) begin
        rnd <= rnd + 7'd1;
        if (rnd == LAST_ROUND) begin
          running <= 1'b0;
        end
      end
      if (ctl.init) begin
        chain <= CHAIN_INIT;
      end else if (fin) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
    end
  end

  // block buffer doubles as the rolling schedule window
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      blk <= {blk[503:0], ctl.data};
    end else if (running) begin
      blk <= {blk[479:0], wt};
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (running) begin
      e <= d;
      d <= c;
      c <= rotl(b, 30);
      b <= a;
      a <= tmp;
    end
  end

  assign stat.busy = running | fin;
  assign stat.done = fin;

  `ASSERT_NEVER(a_start_while_busy, clk, rst, ctl.start && (running || fin), "start during compression")
  `ASSERT_CLK(a_fin_after_last, clk, rst, fin |-> ($past(rnd) == LAST_ROUND), "fold not after round 79")
  `ASSERT_NEVER(a_init_collides, clk, rst, ctl.init && (ctl.load || running || fin), "init while block in use")

endmodule
